FILE: rtl/ldch_pkg.sv
// Shared types, constants and the key function for the download code hash core.
// No dependencies; imported by lyric_download_code_hash_core.
`timescale 1ns / 1ps
`default_nettype none

package ldch_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_RSUM,
      ST_MIX,
      ST_MUL1,
      ST_MUL2,
      ST_OUT
   } ldch_state_type;

   // Reset value of the position weight
   localparam logic [31:0] WEIGHT_INIT = 32'h0000_0001;

   // Byte lanes of the song id
   localparam logic [31:0] LANE0_MASK = 32'h0000_00FF;
   localparam logic [31:0] LANE1_MASK = 32'h0000_FF00;
   localparam logic [31:0] LANE2_MASK = 32'h00FF_0000;
   localparam logic [31:0] LANE3_MASK = 32'hFF00_0000;

   // Shift amounts of the constant multipliers (x*(2^k+1) = (x<<k)+x)
   localparam int unsigned FWD_EVEN_SHIFT = 3;  // times 9
   localparam int unsigned FWD_ODD_SHIFT  = 4;  // times 17
   localparam int unsigned WGT_EVEN_SHIFT = 4;  // times 17
   localparam int unsigned WGT_ODD_SHIFT  = 5;  // times 33

   // Build the byte-permuted key; a zero high lane is replaced by an inverted low lane
   function automatic logic [31:0] make_key(input logic [31:0] id);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [7:0] top;
      logic [7:0] low;
      b0  = 8'((id & LANE0_MASK) >> 0);
      b1  = 8'((id & LANE1_MASK) >> 8);
      b2  = 8'((id & LANE2_MASK) >> 16);
      b3  = 8'((id & LANE3_MASK) >> 24);
      top = (b2 != 8'd0) ? b2 : ~b1;
      low = (b3 != 8'd0) ? b3 : ~b0;
      return {top, b0, b1, low};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lyric_download_code_hash_core.sv
// Top level of the download verification code hash: sequencer, accumulators
// and one shared 32x32 multiplier. Depends on ldch_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes a message one byte per request (artist text then title text, last marks
// the final byte) and returns one signed 32-bit code per message. A byte that is
// not last is multiplied by the position weight in the shared 32x32 multiplier, and
// back in idle the product is added to the reverse sum while the next byte is taken.
// The last byte passes through the weight product, sum and key mix, then two
// products through the same multiplier, before the code is offered, and the block
// then holds the code until it is taken. The song id is sampled with every byte and
// the last one's value is used. After the code is taken, all sums return to reset.
module lyric_download_code_hash_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last,
   input  wire logic signed [31:0] req_song_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_hash_code
);
   import ldch_pkg::*;

   ldch_state_type state_ff, state_in;

   logic [31:0] fwd_sum_ff, fwd_sum_in;
   logic [31:0] rev_sum_ff, rev_sum_in;
   logic [31:0] wgt_ff, wgt_in;
   logic        odd_ff, odd_in;
   logic        pend_ff, pend_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [31:0] id_ff;
   logic [31:0] mix_ff, mix_in;
   logic [31:0] mul_ff, mul_in;

   logic [31:0] byte_sx;
   logic [31:0] key;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] mul_full;
   logic        req_fire;
   logic        rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign byte_sx  = {{24{byte_ff[7]}}, byte_ff};
   assign key      = make_key(id_ff);

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_MAC;
         ST_MAC:  state_in = last_ff ? ST_RSUM : ST_IDLE;
         ST_RSUM: state_in = ST_MIX;
         ST_MIX:  state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_OUT;
         ST_OUT:  if (rsp_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive the handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_OUT:  rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_hash_code = signed'(mul_ff);

   // Select the shared multiplier operands; keep the low 32 product bits
   always_comb begin
      case (state_ff)
         ST_MUL1: begin
            mul_a = mix_ff;
            mul_b = fwd_sum_ff | key;
         end
         ST_MUL2: begin
            mul_a = mul_ff;
            mul_b = rev_sum_ff ^ id_ff;
         end
         default: begin
            mul_a = byte_sx;
            mul_b = wgt_ff;
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   // Update the accumulators and the product register
   always_comb begin
      fwd_sum_in = fwd_sum_ff;
      rev_sum_in = rev_sum_ff;
      wgt_in     = wgt_ff;
      odd_in     = odd_ff;
      pend_in    = pend_ff;
      mix_in     = mix_ff;
      mul_in     = mul_ff;
      case (state_ff)
         ST_IDLE: begin
            // fold the previous byte's weighted value into the reverse sum
            if (pend_ff) begin
               rev_sum_in = rev_sum_ff + mul_ff;
               pend_in    = 1'b0;
            end
         end
         ST_MAC: begin
            mul_in = mul_full;
            if (odd_ff) begin
               fwd_sum_in = (fwd_sum_ff << FWD_ODD_SHIFT) + fwd_sum_ff + byte_sx;
               wgt_in     = (wgt_ff << WGT_ODD_SHIFT) + wgt_ff;
            end else begin
               fwd_sum_in = (fwd_sum_ff << FWD_EVEN_SHIFT) + fwd_sum_ff + byte_sx;
               wgt_in     = (wgt_ff << WGT_EVEN_SHIFT) + wgt_ff;
            end
            odd_in  = ~odd_ff;
            pend_in = ~last_ff;
         end
         ST_RSUM: rev_sum_in = rev_sum_ff + mul_ff;
         ST_MIX:  mix_in = (rev_sum_ff ^ key) + (fwd_sum_ff | id_ff);
         ST_MUL1: mul_in = mul_full;
         ST_MUL2: mul_in = mul_full;
         ST_OUT: begin
            // drop the message state once the code is taken
            if (rsp_fire) begin
               fwd_sum_in = '0;
               rev_sum_in = '0;
               wgt_in     = WEIGHT_INIT;
               odd_in     = 1'b0;
               pend_in    = 1'b0;
            end
         end
         default: begin
            fwd_sum_in = fwd_sum_ff;
         end
      endcase
   end

   // Hold control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fwd_sum_ff <= '0;
         rev_sum_ff <= '0;
         wgt_ff     <= WEIGHT_INIT;
         odd_ff     <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fwd_sum_ff <= fwd_sum_in;
         rev_sum_ff <= rev_sum_in;
         wgt_ff     <= wgt_in;
         odd_ff     <= odd_in;
         pend_ff    <= pend_in;
      end
   end

   // Capture the request payload and working products
   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last;
         id_ff   <= unsigned'(req_song_id);
      end
      mix_ff <= mix_in;
      mul_ff <= mul_in;
   end

   // Never offer a code while taking a request
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response active together");

   // A taken code returns the sums to their reset values
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> fwd_sum_ff == '0 && rev_sum_ff == '0 &&
                                 wgt_ff == WEIGHT_INIT && !odd_ff)
      else $error("state not cleared after code");

   // A byte that is not last frees the input again once the multiply state has passed
   a_rate: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> ##1 req_ready)
      else $error("byte took longer than two cycles");

   // No weighted product is left pending while a code is offered
   a_pend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !pend_ff)
      else $error("pending product at code output");

endmodule

`default_nettype wire
